FILE: rtl/lkv_pkg.sv
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic ins;
        logic keep;
    } cell_ctrl_t;

endpackage

FILE: rtl/lkv_cell.sv
module lkv_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkv_pkg::cell_ctrl_t          ctrl,
    input  logic [lkv_pkg::DATA_W-1:0]   cmp_key,
    input  logic [lkv_pkg::DATA_W-1:0]   up_key,
    input  logic [lkv_pkg::DATA_W-1:0]   up_value,
    input  logic                         up_valid,
    input  logic                         sh_in,
    input  logic [lkv_pkg::DATA_W-1:0]   hv_in,
    output logic [lkv_pkg::DATA_W-1:0]   key_q,
    output logic [lkv_pkg::DATA_W-1:0]   value_q,
    output logic                         valid_q,
    output logic                         sh_out,
    output logic [lkv_pkg::DATA_W-1:0]   hv_out
);

    logic [lkv_pkg::DATA_W-1:0] key_reg;
    logic [lkv_pkg::DATA_W-1:0] value_reg;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       match_reg;
    logic                       match_next;
    logic                       shift;

    // The match flag is taken when the item is accepted and holds until the update.
    assign match_next = ctrl.cmp_en ? (valid_reg && (key_reg == cmp_key)) : match_reg;

    // A cell moves one place back when the hit lies at or behind it, or on an insert.
    assign sh_out = match_reg | sh_in;
    assign shift  = ctrl.upd_en & (ctrl.ins | sh_out);
    assign hv_out = hv_in | (match_reg ? value_reg : '0);

    // Entries pushed beyond the capacity by an insert are dropped.
    assign valid_next = up_valid & (~ctrl.ins | ctrl.keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            if (shift)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= up_key;
            value_reg <= up_value;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign valid_q = valid_reg;

endmodule

FILE: rtl/lru_key_value_cache_top.sv
// The key compare across the cell row is done as an item is transferred in;
// the move-to-front shift of the row and the registering of the result follow
// in the update state, and no new item is taken until that state is left.
// Reset clears every entry's valid bit and sets capacity to 16; a full output
// register that is stalled holds the row in its update cycle.
module lru_key_value_cache_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic signed [lkv_pkg::DATA_W-1:0] key,
    input  logic signed [lkv_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [lkv_pkg::DATA_W-1:0] read_value
);

    localparam int N = lkv_pkg::MAX_ENTRIES;

    lkv_pkg::state_t state_reg;
    lkv_pkg::state_t state_next;

    logic [lkv_pkg::CAP_W-1:0]  cap_reg;
    logic [lkv_pkg::CNT_W-1:0]  eff_cap;

    logic                       func_reg;
    logic [lkv_pkg::DATA_W-1:0] key_reg;
    logic [lkv_pkg::DATA_W-1:0] value_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       hit_reg;
    logic [lkv_pkg::DATA_W-1:0] read_value_reg;

    logic                       accept;
    logic                       upd_fire;
    logic [lkv_pkg::DATA_W-1:0] front_value;

    logic [lkv_pkg::DATA_W-1:0] key_q   [N];
    logic [lkv_pkg::DATA_W-1:0] value_q [N];
    logic                       valid_q [N];
    logic                       sh_out  [N];
    logic [lkv_pkg::DATA_W-1:0] hv_out  [N];

    assign accept   = in_valid && (state_reg == lkv_pkg::ST_IDLE);
    assign upd_fire = (state_reg == lkv_pkg::ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != lkv_pkg::ST_IDLE);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end
        else if (int'(cap_reg) > N)
        begin
            eff_cap = lkv_pkg::CNT_W'(N);
        end
        else
        begin
            eff_cap = lkv_pkg::CNT_W'(cap_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lkv_pkg::ST_UPDATE;
                end
            end
            lkv_pkg::ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::ST_IDLE;
            cap_reg       <= lkv_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            key_reg   <= key;
            value_reg <= value;
        end
        if (upd_fire)
        begin
            hit_reg        <= sh_out[0];
            read_value_reg <= (!func_reg && sh_out[0]) ? hv_out[0] : '0;
        end
    end

    // The most recent place takes the item's key, with the new value on a store
    // and the found value on a lookup.
    assign front_value = func_reg ? value_reg : hv_out[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lkv_pkg::cell_ctrl_t        ctrl;
        logic [lkv_pkg::DATA_W-1:0] up_key;
        logic [lkv_pkg::DATA_W-1:0] up_value;
        logic                       up_valid;
        logic                       sh_in;
        logic [lkv_pkg::DATA_W-1:0] hv_in;

        assign ctrl.cmp_en = accept;
        assign ctrl.upd_en = upd_fire;
        assign ctrl.ins    = func_reg && !sh_out[0];
        assign ctrl.keep   = (eff_cap > lkv_pkg::CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign up_key   = key_reg;
            assign up_value = front_value;
            assign up_valid = 1'b1;
        end
        else
        begin : g_body
            assign up_key   = key_q[i-1];
            assign up_value = value_q[i-1];
            assign up_valid = valid_q[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign sh_in = 1'b0;
            assign hv_in = '0;
        end
        else
        begin : g_link
            assign sh_in = sh_out[i+1];
            assign hv_in = hv_out[i+1];
        end

        lkv_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .cmp_key  (key),
            .up_key   (up_key),
            .up_value (up_value),
            .up_valid (up_valid),
            .sh_in    (sh_in),
            .hv_in    (hv_in),
            .key_q    (key_q[i]),
            .value_q  (value_q[i]),
            .valid_q  (valid_q[i]),
            .sh_out   (sh_out[i]),
            .hv_out   (hv_out[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule
